// ===== rtl/rwcp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcp_pkg: shared constants for the RIFF/WAVE chunk parser
// Status codes, chunk tags and register indexes used by the parser.
// ----------------------------------------------------------------------------
package rwcp_pkg;

  // Result status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusShort     = 3'd1;
  localparam logic [2:0] StatusNotRiff   = 3'd2;
  localparam logic [2:0] StatusTruncated = 3'd3;
  localparam logic [2:0] StatusBadFormat = 3'd4;
  localparam logic [2:0] StatusNoFmt     = 3'd5;
  localparam logic [2:0] StatusNoData    = 3'd6;
  localparam logic [2:0] StatusPending   = 3'd7;

  // Four-character tags, first byte in the top position
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegBufferLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFormatTag    = 2'd1;

  // Fixed header geometry
  localparam logic [32:0] RiffTagLastPos = 33'd3;
  localparam logic [32:0] WaveTagLastPos = 33'd11;
  localparam logic [33:0] FirstHdrEnd    = 34'd20;
  localparam logic [31:0] MinBufferLen   = 32'd12;
  localparam logic [31:0] MinFmtSize     = 32'd16;
  localparam logic [31:0] ExtFmtSize     = 32'd18;
  localparam logic [33:0] HdrLen         = 34'd8;

  // Format payload bytes kept
  localparam int unsigned FmtBytes = 18;
  localparam int unsigned FmtOffW  = 5;
  localparam logic [FmtOffW-1:0] FmtLastBasic = 5'd15;
  localparam logic [FmtOffW-1:0] FmtLastExt   = 5'd17;
  localparam logic [FmtOffW-1:0] FmtOffSat    = 5'd18;
  localparam logic [FmtOffW-1:0] FmtTagHiOff  = 5'd1;

endpackage

// ===== rtl/riff_wave_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_parser: streaming RIFF/WAVE header parser
// Walks the chunk list of a byte stream, captures the fmt fields and the
// data chunk location, and reports one status word on the last byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//  out     | output    | out_valid_o/out_ready_i | status_o and nine format fields
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_ready_o is high; the parse state updates at the accepting edge
// and the result word sits in an output register from the next cycle.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset returns the parse state to the RIFF header phase and the registers
// to their defaults; the parse state also clears after each last byte.
// cfg_ready_o is always high.
module riff_wave_chunk_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [15:0]                  wave_format_o,
  output logic [15:0]                  channel_count_o,
  output logic [31:0]                  sample_freq_o,
  output logic [31:0]                  byte_rate_o,
  output logic [15:0]                  block_alignment_o,
  output logic [15:0]                  sample_bits_o,
  output logic [15:0]                  extra_size_o,
  output logic [31:0]                  payload_offset_o,
  output logic [31:0]                  payload_length_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rwcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  typedef enum logic [2:0] {
    PhRiff,
    PhHdr,
    PhPayload,
    PhPad,
    PhDone
  } phase_e;

  // Registers
  logic [31:0] buf_len_q;
  logic [15:0] acc_tag_q;

  // Parse state
  phase_e       phase_q, phase_d;
  logic [32:0]  pos_q, pos_d;
  logic [55:0]  shift_q, shift_d;
  logic [31:0]  size_q, size_d;
  logic [33:0]  end_q, end_d;
  logic         is_fmt_q, is_fmt_d;
  logic         seen_fmt_q, seen_fmt_d;
  logic         seen_data_q, seen_data_d;
  logic [2:0]   decided_q, decided_d;
  logic [rwcp_pkg::FmtOffW-1:0] fmt_off_q, fmt_off_d;
  logic [7:0]   fmt_byte_q [rwcp_pkg::FmtBytes];
  logic [7:0]   fmt_byte_d [rwcp_pkg::FmtBytes];
  logic [31:0]  data_off_q, data_off_d;
  logic [31:0]  data_len_q, data_len_d;

  // Result register
  logic         out_valid_q, out_valid_d;
  logic [2:0]   status_q, status_d;
  logic [15:0]  wave_format_q, wave_format_d;
  logic [15:0]  channel_count_q, channel_count_d;
  logic [31:0]  sample_freq_q, sample_freq_d;
  logic [31:0]  byte_rate_q, byte_rate_d;
  logic [15:0]  block_alignment_q, block_alignment_d;
  logic [15:0]  sample_bits_q, sample_bits_d;
  logic [15:0]  extra_size_q, extra_size_d;
  logic [31:0]  payload_offset_q, payload_offset_d;
  logic [31:0]  payload_length_q, payload_length_d;

  // Per-byte helpers
  logic         in_acc;
  logic         consume;
  logic         at_end;
  logic [31:0]  hdr_id;
  logic [31:0]  hdr_size;
  logic [34:0]  hdr_sum;
  logic [rwcp_pkg::FmtOffW-1:0] fmt_last;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Chunk id and little-endian size as seen with the incoming byte
  assign consume  = (pos_q < {1'b0, buf_len_q});
  assign at_end   = (({1'b0, pos_q} + 34'd1) == end_q);
  assign hdr_id   = shift_q[55:24];
  assign hdr_size = {data_byte_i, shift_q[7:0], shift_q[15:8], shift_q[23:16]};
  assign hdr_sum  = {1'b0, end_q} + {3'b000, hdr_size};
  assign fmt_last = (size_q >= rwcp_pkg::ExtFmtSize) ? rwcp_pkg::FmtLastExt
                                                     : rwcp_pkg::FmtLastBasic;

  // Advance the parse state by one word and build the result on the last one
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    shift_d     = shift_q;
    size_d      = size_q;
    end_d       = end_q;
    is_fmt_d    = is_fmt_q;
    seen_fmt_d  = seen_fmt_q;
    seen_data_d = seen_data_q;
    decided_d   = decided_q;
    fmt_off_d   = fmt_off_q;
    fmt_byte_d  = fmt_byte_q;
    data_off_d  = data_off_q;
    data_len_d  = data_len_q;

    out_valid_d       = out_valid_q && !out_ready_i;
    status_d          = status_q;
    wave_format_d     = wave_format_q;
    channel_count_d   = channel_count_q;
    sample_freq_d     = sample_freq_q;
    byte_rate_d       = byte_rate_q;
    block_alignment_d = block_alignment_q;
    sample_bits_d     = sample_bits_q;
    extra_size_d      = extra_size_q;
    payload_offset_d  = payload_offset_q;
    payload_length_d  = payload_length_q;

    if (in_acc && consume) begin
      shift_d = {shift_q[47:0], data_byte_i};
      pos_d   = pos_q + 33'd1;
      case (phase_q)
        // Check the RIFF and WAVE tags
        PhRiff: begin
          if (pos_q == rwcp_pkg::RiffTagLastPos && shift_d[31:0] != rwcp_pkg::TagRiff) begin
            decided_d = rwcp_pkg::StatusNotRiff;
            phase_d   = PhDone;
          end else if (pos_q == rwcp_pkg::WaveTagLastPos) begin
            if (shift_d[31:0] != rwcp_pkg::TagWave) begin
              decided_d = rwcp_pkg::StatusNotRiff;
              phase_d   = PhDone;
            end else begin
              phase_d = PhHdr;
              end_d   = rwcp_pkg::FirstHdrEnd;
            end
          end
        end
        // Decode a chunk header on its eighth byte
        PhHdr: begin
          if (at_end) begin
            size_d   = hdr_size;
            is_fmt_d = 1'b0;
            if (hdr_sum > {3'b000, buf_len_q}) begin
              decided_d = rwcp_pkg::StatusTruncated;
              phase_d   = PhDone;
            end else if (hdr_id == rwcp_pkg::TagFmt && hdr_size < rwcp_pkg::MinFmtSize) begin
              decided_d = rwcp_pkg::StatusTruncated;
              phase_d   = PhDone;
            end else if (hdr_id == rwcp_pkg::TagData && seen_fmt_q) begin
              data_off_d  = end_q[31:0];
              data_len_d  = hdr_size;
              seen_data_d = 1'b1;
              decided_d   = rwcp_pkg::StatusOk;
              phase_d     = PhDone;
            end else begin
              if (hdr_id == rwcp_pkg::TagFmt) begin
                for (int i = 0; i < rwcp_pkg::FmtBytes; i++) begin
                  fmt_byte_d[i] = 8'h00;
                end
                is_fmt_d  = 1'b1;
                fmt_off_d = '0;
              end else if (hdr_id == rwcp_pkg::TagData) begin
                data_off_d  = end_q[31:0];
                data_len_d  = hdr_size;
                seen_data_d = 1'b1;
              end
              if (hdr_size == 32'd0) begin
                phase_d = PhHdr;
                end_d   = hdr_sum[33:0] + rwcp_pkg::HdrLen;
              end else begin
                phase_d = PhPayload;
                end_d   = hdr_sum[33:0];
              end
            end
          end
        end
        // Capture fmt fields, then step past the payload
        PhPayload: begin
          if (is_fmt_q && fmt_off_q <= fmt_last) begin
            for (int i = 0; i < rwcp_pkg::FmtBytes; i++) begin
              if (fmt_off_q == i[rwcp_pkg::FmtOffW-1:0]) begin
                fmt_byte_d[i] = data_byte_i;
              end
            end
          end
          if (is_fmt_q && fmt_off_q != rwcp_pkg::FmtOffSat) begin
            fmt_off_d = fmt_off_q + rwcp_pkg::FmtOffW'(1);
          end
          if (is_fmt_q && fmt_off_q == rwcp_pkg::FmtTagHiOff &&
              {data_byte_i, fmt_byte_q[0]} != acc_tag_q) begin
            decided_d = rwcp_pkg::StatusBadFormat;
            phase_d   = PhDone;
          end else if (is_fmt_q && fmt_off_q == fmt_last && seen_data_q) begin
            seen_fmt_d = 1'b1;
            decided_d  = rwcp_pkg::StatusOk;
            phase_d    = PhDone;
          end else begin
            if (is_fmt_q && fmt_off_q == fmt_last) begin
              seen_fmt_d = 1'b1;
            end
            if (at_end) begin
              if (size_q[0]) begin
                phase_d = PhPad;
                end_d   = end_q + 34'd1;
              end else begin
                phase_d = PhHdr;
                end_d   = end_q + rwcp_pkg::HdrLen;
              end
            end
          end
        end
        // Skip the pad byte of an odd payload
        PhPad: begin
          if (at_end) begin
            phase_d = PhHdr;
            end_d   = end_q + rwcp_pkg::HdrLen;
          end
        end
        default: begin
        end
      endcase
    end

    // Load the result word and restart the parse
    if (in_acc && last_byte_i) begin
      out_valid_d = 1'b1;
      if (buf_len_q < rwcp_pkg::MinBufferLen) begin
        status_d = rwcp_pkg::StatusShort;
      end else if (decided_d != rwcp_pkg::StatusPending) begin
        status_d = decided_d;
      end else if (pos_d < {1'b0, buf_len_q}) begin
        status_d = rwcp_pkg::StatusTruncated;
      end else if (!seen_fmt_d) begin
        status_d = rwcp_pkg::StatusNoFmt;
      end else if (!seen_data_d) begin
        status_d = rwcp_pkg::StatusNoData;
      end else begin
        status_d = rwcp_pkg::StatusOk;
      end

      if (status_d == rwcp_pkg::StatusOk) begin
        wave_format_d     = {fmt_byte_d[1], fmt_byte_d[0]};
        channel_count_d   = {fmt_byte_d[3], fmt_byte_d[2]};
        sample_freq_d     = {fmt_byte_d[7], fmt_byte_d[6], fmt_byte_d[5], fmt_byte_d[4]};
        byte_rate_d       = {fmt_byte_d[11], fmt_byte_d[10], fmt_byte_d[9], fmt_byte_d[8]};
        block_alignment_d = {fmt_byte_d[13], fmt_byte_d[12]};
        sample_bits_d     = {fmt_byte_d[15], fmt_byte_d[14]};
        extra_size_d      = {fmt_byte_d[17], fmt_byte_d[16]};
        payload_offset_d  = data_off_d;
        payload_length_d  = data_len_d;
      end else begin
        wave_format_d     = '0;
        channel_count_d   = '0;
        sample_freq_d     = '0;
        byte_rate_d       = '0;
        block_alignment_d = '0;
        sample_bits_d     = '0;
        extra_size_d      = '0;
        payload_offset_d  = '0;
        payload_length_d  = '0;
      end

      phase_d     = PhRiff;
      pos_d       = '0;
      shift_d     = '0;
      size_d      = '0;
      end_d       = '0;
      is_fmt_d    = 1'b0;
      seen_fmt_d  = 1'b0;
      seen_data_d = 1'b0;
      decided_d   = rwcp_pkg::StatusPending;
      fmt_off_d   = '0;
    end
  end

  // Hold state, registers and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q         <= '0;
      acc_tag_q         <= 16'd34;
      phase_q           <= PhRiff;
      pos_q             <= '0;
      shift_q           <= '0;
      size_q            <= '0;
      end_q             <= '0;
      is_fmt_q          <= 1'b0;
      seen_fmt_q        <= 1'b0;
      seen_data_q       <= 1'b0;
      decided_q         <= rwcp_pkg::StatusPending;
      fmt_off_q         <= '0;
      for (int i = 0; i < rwcp_pkg::FmtBytes; i++) begin
        fmt_byte_q[i] <= 8'h00;
      end
      data_off_q        <= '0;
      data_len_q        <= '0;
      out_valid_q       <= 1'b0;
      status_q          <= '0;
      wave_format_q     <= '0;
      channel_count_q   <= '0;
      sample_freq_q     <= '0;
      byte_rate_q       <= '0;
      block_alignment_q <= '0;
      sample_bits_q     <= '0;
      extra_size_q      <= '0;
      payload_offset_q  <= '0;
      payload_length_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rwcp_pkg::RegBufferLength: buf_len_q <= cfg_data_i;
          rwcp_pkg::RegFormatTag:    acc_tag_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      phase_q           <= phase_d;
      pos_q             <= pos_d;
      shift_q           <= shift_d;
      size_q            <= size_d;
      end_q             <= end_d;
      is_fmt_q          <= is_fmt_d;
      seen_fmt_q        <= seen_fmt_d;
      seen_data_q       <= seen_data_d;
      decided_q         <= decided_d;
      fmt_off_q         <= fmt_off_d;
      fmt_byte_q        <= fmt_byte_d;
      data_off_q        <= data_off_d;
      data_len_q        <= data_len_d;
      out_valid_q       <= out_valid_d;
      status_q          <= status_d;
      wave_format_q     <= wave_format_d;
      channel_count_q   <= channel_count_d;
      sample_freq_q     <= sample_freq_d;
      byte_rate_q       <= byte_rate_d;
      block_alignment_q <= block_alignment_d;
      sample_bits_q     <= sample_bits_d;
      extra_size_q      <= extra_size_d;
      payload_offset_q  <= payload_offset_d;
      payload_length_q  <= payload_length_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign wave_format_o     = wave_format_q;
  assign channel_count_o   = channel_count_q;
  assign sample_freq_o     = sample_freq_q;
  assign byte_rate_o       = byte_rate_q;
  assign block_alignment_o = block_alignment_q;
  assign sample_bits_o     = sample_bits_q;
  assign extra_size_o      = extra_size_q;
  assign payload_offset_o  = payload_offset_q;
  assign payload_length_o  = payload_length_q;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the RIFF/WAVE chunk parser
// Streams byte buffers through the parser, one word per handshake, and checks
// every status word against an in-bench walk of the same RIFF chunk list.
// Directed buffers cover the header tags, each error status, padding, format
// extensions and the length register extremes; random buffers follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          WatchLimit = 400;
  localparam logic [31:0] BadRiffTag = 32'h5249_4658;
  localparam logic [31:0] BadWaveTag = 32'h5741_5646;
  localparam logic [31:0] JunkTag    = 32'h4C49_5354;

  typedef enum logic [2:0] {WalkRiff, WalkHeader, WalkBody, WalkPad, WalkStop} walk_phase_e;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] wave_format;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [31:0] byte_rate;
    logic [15:0] block_alignment;
    logic [15:0] sample_bits;
    logic [15:0] extra_size;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
  } wave_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [15:0]        wave_format_o;
  logic [15:0]        channel_count_o;
  logic [31:0]        sample_freq_o;
  logic [31:0]        byte_rate_o;
  logic [15:0]        block_alignment_o;
  logic [15:0]        sample_bits_o;
  logic [15:0]        extra_size_o;
  logic [31:0]        payload_offset_o;
  logic [31:0]        payload_length_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [rwcp_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0]        cfg_data_i;

  // Register copies and walk state of the predictor
  logic [31:0]  len_reg;
  logic [15:0]  tag_reg;
  logic [32:0]  walk_pos;
  walk_phase_e  walk_phase;
  logic [63:0]  hdr_window;
  logic [31:0]  cur_chunk_size;
  logic [33:0]  cur_chunk_end;
  logic         in_fmt_chunk;
  logic         fmt_seen;
  logic         data_seen;
  logic [2:0]   verdict;
  logic [63:0]  fields [4];

  wave_report_t pending_reports [$];
  logic [7:0]   frame [$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  int           out_hold = 0;
  bit           steady = 1'b0;

  riff_wave_chunk_parser dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void restart_walk();
    walk_pos       = '0;
    walk_phase     = WalkRiff;
    hdr_window     = '0;
    cur_chunk_size = '0;
    cur_chunk_end  = '0;
    in_fmt_chunk   = 1'b0;
    fmt_seen       = 1'b0;
    data_seen      = 1'b0;
    verdict        = rwcp_pkg::StatusPending;
    for (int k = 0; k < 4; k++) fields[k] = '0;
  endfunction

  function automatic void settle(input logic [2:0] s);
    verdict    = s;
    walk_phase = WalkStop;
  endfunction

  // Step past the chunk payload: into the pad byte or the next header
  function automatic void close_chunk();
    if (cur_chunk_size[0]) begin
      walk_phase    = WalkPad;
      cur_chunk_end = cur_chunk_end + 34'd1;
    end else begin
      walk_phase    = WalkHeader;
      cur_chunk_end = cur_chunk_end + rwcp_pkg::HdrLen;
    end
  endfunction

  // Advance the chunk walk by one accepted word; queue a report on the last one
  function automatic void wave_parse_step(input logic [7:0] b, input logic fin);
    logic [31:0]  id;
    logic [31:0]  sz;
    logic [33:0]  off;
    logic [4:0]   last_off;
    logic         done;
    logic [2:0]   st;
    wave_report_t rep;

    if (walk_pos < {1'b0, len_reg}) begin
      hdr_window = {hdr_window[55:0], b};
      case (walk_phase)
        WalkRiff: begin
          if (walk_pos == rwcp_pkg::RiffTagLastPos &&
              hdr_window[31:0] != rwcp_pkg::TagRiff) begin
            settle(rwcp_pkg::StatusNotRiff);
          end else if (walk_pos == rwcp_pkg::WaveTagLastPos) begin
            if (hdr_window[31:0] != rwcp_pkg::TagWave) begin
              settle(rwcp_pkg::StatusNotRiff);
            end else begin
              walk_phase    = WalkHeader;
              cur_chunk_end = rwcp_pkg::FirstHdrEnd;
            end
          end
        end
        WalkHeader: begin
          if ({1'b0, walk_pos} + 34'd1 == cur_chunk_end) begin
            id = hdr_window[63:32];
            sz = {hdr_window[7:0], hdr_window[15:8], hdr_window[23:16], hdr_window[31:24]};
            cur_chunk_size = sz;
            in_fmt_chunk   = 1'b0;
            if (cur_chunk_end + {2'b00, sz} > {2'b00, len_reg}) begin
              settle(rwcp_pkg::StatusTruncated);
            end else if (id == rwcp_pkg::TagFmt && sz < rwcp_pkg::MinFmtSize) begin
              settle(rwcp_pkg::StatusTruncated);
            end else begin
              if (id == rwcp_pkg::TagFmt) begin
                fields[0]    = '0;
                fields[1]    = '0;
                fields[2]    = '0;
                in_fmt_chunk = 1'b1;
              end else if (id == rwcp_pkg::TagData) begin
                fields[3] = {sz, cur_chunk_end[31:0]};
                data_seen = 1'b1;
              end
              if (id == rwcp_pkg::TagData && fmt_seen) begin
                settle(rwcp_pkg::StatusOk);
              end else begin
                cur_chunk_end = cur_chunk_end + {2'b00, sz};
                if (sz == '0) close_chunk();
                else walk_phase = WalkBody;
              end
            end
          end
        end
        WalkBody: begin
          done = 1'b0;
          if (in_fmt_chunk) begin
            off      = {1'b0, walk_pos} - (cur_chunk_end - {2'b00, cur_chunk_size});
            last_off = (cur_chunk_size >= rwcp_pkg::ExtFmtSize) ? rwcp_pkg::FmtLastExt
                                                                : rwcp_pkg::FmtLastBasic;
            if (off <= {29'd0, last_off}) begin
              fields[off[4:3]][{off[2:0], 3'b000} +: 8] = b;
              if (off == {29'd0, rwcp_pkg::FmtTagHiOff} && fields[0][15:0] != tag_reg) begin
                settle(rwcp_pkg::StatusBadFormat);
                done = 1'b1;
              end else if (off == {29'd0, last_off}) begin
                fmt_seen = 1'b1;
                if (data_seen) begin
                  settle(rwcp_pkg::StatusOk);
                  done = 1'b1;
                end
              end
            end
          end
          if (!done && {1'b0, walk_pos} + 34'd1 == cur_chunk_end) close_chunk();
        end
        WalkPad: begin
          if ({1'b0, walk_pos} + 34'd1 == cur_chunk_end) begin
            walk_phase    = WalkHeader;
            cur_chunk_end = cur_chunk_end + rwcp_pkg::HdrLen;
          end
        end
        default: ;
      endcase
      walk_pos = walk_pos + 33'd1;
    end

    if (fin) begin
      if (len_reg < rwcp_pkg::MinBufferLen) st = rwcp_pkg::StatusShort;
      else if (verdict != rwcp_pkg::StatusPending) st = verdict;
      else if (walk_pos < {1'b0, len_reg}) st = rwcp_pkg::StatusTruncated;
      else if (!fmt_seen) st = rwcp_pkg::StatusNoFmt;
      else if (!data_seen) st = rwcp_pkg::StatusNoData;
      else st = rwcp_pkg::StatusOk;

      rep = '{default: '0};
      rep.status = st;
      if (st == rwcp_pkg::StatusOk) begin
        rep.wave_format     = fields[0][15:0];
        rep.channel_count   = fields[0][31:16];
        rep.sample_freq     = fields[0][63:32];
        rep.byte_rate       = fields[1][31:0];
        rep.block_alignment = fields[1][47:32];
        rep.sample_bits     = fields[1][63:48];
        rep.extra_size      = fields[2][15:0];
        rep.payload_offset  = fields[3][31:0];
        rep.payload_length  = fields[3][63:32];
      end
      pending_reports.push_back(rep);
      restart_walk();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Buffer builders
  // ---------------------------------------------------------------------------
  function automatic void put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) frame.push_back(t[i*8 +: 8]);
  endfunction

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) frame.push_back(v[i*8 +: 8]);
  endfunction

  function automatic void put_noise(input int n);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_wave_head();
    put_tag(rwcp_pkg::TagRiff);
    put_le($urandom, 4);
    put_tag(rwcp_pkg::TagWave);
  endfunction

  // Chunk with random payload, padded to an even length
  function automatic void put_chunk(input logic [31:0] id, input int unsigned size);
    put_tag(id);
    put_le(size, 4);
    put_noise(size + size % 2);
  endfunction

  // fmt chunk with the given tag and random remaining fields
  function automatic void put_fmt(input logic [15:0] tag, input int unsigned size);
    put_tag(rwcp_pkg::TagFmt);
    put_le(size, 4);
    put_le(32'(tag), 2);
    put_noise(size - 2 + size % 2);
  endfunction

  // Extended fmt chunk whose every field byte holds the same value
  function automatic void put_flat_fmt(input logic [7:0] v);
    put_tag(rwcp_pkg::TagFmt);
    put_le(32'd18, 4);
    repeat (18) frame.push_back(v);
  endfunction

  // Mostly well-formed chunk lists with random content; some noise and damage
  function automatic logic [31:0] build_random_frame();
    int unsigned pick;
    int unsigned sz;
    logic [31:0] len;
    logic [15:0] tg;

    frame.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      put_noise($urandom_range(1, 40));
      return (pick < 3) ? frame.size() : $urandom_range(0, 48);
    end
    put_wave_head();
    for (int i = 0; i < $urandom_range(1, 4); i++) begin
      pick = (i == 0 && $urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 9);
      if (pick < 4) begin
        sz = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 26)
                                         : ($urandom_range(0, 1) ? 16 : 18);
        tg = ($urandom_range(0, 7) == 0) ? 16'($urandom) : tag_reg;
        put_fmt(tg, sz);
      end else if (pick < 7) begin
        put_chunk(rwcp_pkg::TagData, $urandom_range(0, 24));
      end else begin
        put_chunk($urandom_range(0, 1) ? JunkTag : $urandom, $urandom_range(0, 9));
      end
    end
    len = frame.size();
    case ($urandom_range(0, 9))
      0: len = len - $urandom_range(1, 16);
      1: len = len + $urandom_range(1, 16);
      2: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
      3: repeat ($urandom_range(1, 12)) void'(frame.pop_back());
      default: ;
    endcase
    return len;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Write one register once the parser has gone quiet
  task automatic write_reg(input logic [rwcp_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rwcp_pkg::RegBufferLength) len_reg = val;
    else if (idx == rwcp_pkg::RegFormatTag) tag_reg = val[15:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drive one input word, with an optional idle burst ahead of it
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (!steady && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    wave_parse_step(b, fin);
    @(negedge clk_i);
  endtask

  // Program the length, then stream the frame with last on its final word
  task automatic run_frame(input logic [31:0] len);
    write_reg(rwcp_pkg::RegBufferLength, len);
    for (int i = 0; i < frame.size(); i++) push_byte(frame[i], i == frame.size() - 1);
    in_valid_i <= 1'b0;
    bytes_sent += frame.size();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, output stalls and watchdog
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    wave_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word: expected none, actual status %0d",
                 $time, status_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("wave_format", 32'(want.wave_format), 32'(wave_format_o));
        check_field("channel_count", 32'(want.channel_count), 32'(channel_count_o));
        check_field("sample_freq", want.sample_freq, sample_freq_o);
        check_field("byte_rate", want.byte_rate, byte_rate_o);
        check_field("block_alignment", 32'(want.block_alignment), 32'(block_alignment_o));
        check_field("sample_bits", 32'(want.sample_bits), 32'(sample_bits_o));
        check_field("extra_size", 32'(want.extra_size), 32'(extra_size_o));
        check_field("payload_offset", want.payload_offset, payload_offset_o);
        check_field("payload_length", want.payload_length, payload_length_o);
      end
    end
  end

  // Hold out_ready low in random bursts
  always @(negedge clk_i) begin
    if (out_hold > 0) begin
      out_hold    <= out_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      out_hold    <= $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("riff_wave_chunk_parser test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Lengths under the minimum give the short status whatever the bytes hold
  task automatic test_short_buffers();
    frame.delete();
    frame.push_back(8'h00);
    run_frame(32'd0);
    frame.delete();
    put_wave_head();
    void'(frame.pop_back());
    run_frame(frame.size());
  endtask

  task automatic test_header_tags();
    frame.delete();
    put_tag(BadRiffTag);
    put_le($urandom, 4);
    put_tag(rwcp_pkg::TagWave);
    run_frame(frame.size());
    frame.delete();
    put_tag(rwcp_pkg::TagRiff);
    put_le($urandom, 4);
    put_tag(BadWaveTag);
    run_frame(frame.size());
  endtask

  task automatic test_good_files();
    // default tag, plain 16-byte fmt then data
    frame.delete();
    put_wave_head();
    put_fmt(16'd34, 16);
    put_chunk(rwcp_pkg::TagData, 8);
    run_frame(frame.size());
    write_reg(rwcp_pkg::RegFormatTag, 32'd1);
    // odd junk chunk with pad, extended fmt, empty data
    frame.delete();
    put_wave_head();
    put_chunk(JunkTag, 5);
    put_fmt(16'd1, 18);
    put_chunk(rwcp_pkg::TagData, 0);
    run_frame(frame.size());
    // data ahead of fmt, with an empty chunk between
    frame.delete();
    put_wave_head();
    put_chunk(rwcp_pkg::TagData, 3);
    put_chunk(JunkTag, 0);
    put_fmt(16'd1, 16);
    run_frame(frame.size());
    // second fmt chunk replaces the first
    frame.delete();
    put_wave_head();
    put_fmt(16'd1, 20);
    put_fmt(16'd1, 16);
    put_chunk(rwcp_pkg::TagData, 2);
    run_frame(frame.size());
    // field extremes
    write_reg(rwcp_pkg::RegFormatTag, 32'hFFFF_FFFF);
    frame.delete();
    put_wave_head();
    put_flat_fmt(8'hFF);
    put_chunk(rwcp_pkg::TagData, 1);
    run_frame(frame.size());
    write_reg(rwcp_pkg::RegFormatTag, 32'd0);
    frame.delete();
    put_wave_head();
    put_flat_fmt(8'h00);
    put_chunk(rwcp_pkg::TagData, 0);
    run_frame(frame.size());
  endtask

  task automatic test_walk_errors();
    logic [31:0] len;
    write_reg(rwcp_pkg::RegFormatTag, 32'd1);
    // last word arrives before the programmed length
    frame.delete();
    put_wave_head();
    put_fmt(16'd1, 16);
    put_chunk(rwcp_pkg::TagData, 4);
    len = frame.size();
    repeat (20) void'(frame.pop_back());
    run_frame(len);
    // fmt chunk runs past the end; trailing words are ignored
    frame.delete();
    put_wave_head();
    put_fmt(16'd1, 16);
    run_frame(32'd30);
    // fmt chunk under 16 bytes
    frame.delete();
    put_wave_head();
    put_chunk(rwcp_pkg::TagFmt, 14);
    put_chunk(rwcp_pkg::TagData, 0);
    run_frame(frame.size());
    // format tag other than the programmed one
    frame.delete();
    put_wave_head();
    put_fmt(16'd2, 16);
    put_chunk(rwcp_pkg::TagData, 0);
    run_frame(frame.size());
    // walk runs out with no fmt chunk
    frame.delete();
    put_wave_head();
    put_chunk(rwcp_pkg::TagData, 4);
    put_noise(5);
    run_frame(frame.size());
    // walk runs out with no data chunk
    frame.delete();
    put_wave_head();
    put_fmt(16'd1, 16);
    put_chunk(JunkTag, 3);
    put_noise(7);
    run_frame(frame.size());
    // data chunk lies beyond the programmed length
    frame.delete();
    put_wave_head();
    put_fmt(16'd1, 16);
    len = frame.size();
    put_chunk(rwcp_pkg::TagData, 4);
    run_frame(len);
  endtask

  task automatic test_length_extremes();
    write_reg(rwcp_pkg::RegFormatTag, 32'h0000_FFFF);
    // huge data chunk fits a full-range length; result on the data header
    frame.delete();
    put_wave_head();
    put_flat_fmt(8'hFF);
    put_tag(rwcp_pkg::TagData);
    put_le(32'hFFFF_FFFF - 32'd46, 4);
    run_frame(32'hFFFF_FFFF);
    frame.delete();
    put_wave_head();
    put_fmt(16'hFFFF, 16);
    repeat (4) void'(frame.pop_back());
    run_frame(32'hFFFF_FFFF);
  endtask

  task automatic test_random_streams(input int target);
    int          start;
    int          frames;
    logic [15:0] tag_next;
    start  = bytes_sent;
    frames = 0;
    while (bytes_sent - start < target) begin
      if (frames % 6 == 0) begin
        case ($urandom_range(0, 4))
          0: tag_next = 16'd1;
          1: tag_next = 16'd34;
          2: tag_next = 16'h0000;
          3: tag_next = 16'hFFFF;
          default: tag_next = 16'($urandom);
        endcase
        write_reg(rwcp_pkg::RegFormatTag, {16'($urandom), tag_next});
      end
      run_frame(build_random_frame());
      frames++;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rwcp_pkg::RegBufferLength;
    cfg_data_i  = '0;
    len_reg     = '0;
    tag_reg     = 16'd34;
    restart_walk();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_buffers();
    test_header_tags();
    test_good_files();
    test_walk_errors();
    test_length_extremes();
    test_random_streams(900);
    steady = 1'b1;
    test_random_streams(270);

    // drain the last result, then allow a few quiet cycles
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("riff_wave_chunk_parser test passed");
    end else begin
      $display("riff_wave_chunk_parser test failed");
    end
    $finish;
  end

endmodule
